FILE: sv/cramer_3x3_solver_defines.svh
// assertion macros shared by the cramer 3x3 solver rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CRAMER_3X3_SOLVER_DEFINES_SVH
`define CRAMER_3X3_SOLVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSOL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cramer solver assertion failed");

// next-cycle implication, checked out of reset
`define CSOL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cramer solver assertion failed");

`endif

FILE: sv/csol_pkg.sv
// shared constants and index helpers for the cramer 3x3 solver
// no dependencies
package csol_pkg;

    localparam int OUT_W    = 48;
    localparam int NUM_DET  = 4;
    localparam int NUM_PAIR = 6;
    localparam int NUM_COL  = 4;

    // column pairs of rows two and three; column 3 is the constant column
    localparam int PAIR_P [NUM_PAIR] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_Q [NUM_PAIR] = '{1, 2, 3, 2, 3, 3};

    // columns used by each determinant: main, then constants in column 0, 1, 2
    localparam int DET_COL [NUM_DET][3] = '{'{0, 1, 2}, '{3, 1, 2}, '{0, 3, 2}, '{0, 1, 3}};

    // first-row column of term j of determinant d
    function automatic int f_term_col(input int d, input int j);
        return DET_COL[d][j];
    endfunction

    // the two columns left over for the 2x2 minor of term j
    function automatic int f_other_a(input int d, input int j);
        return (j == 0) ? DET_COL[d][1] : DET_COL[d][0];
    endfunction

    function automatic int f_other_b(input int d, input int j);
        return (j == 2) ? DET_COL[d][1] : DET_COL[d][2];
    endfunction

    // index of the stored minor for the unordered column pair
    function automatic int f_term_pair(input int d, input int j);
        int lo;
        int hi;
        int idx;
        lo  = (f_other_a(d, j) < f_other_b(d, j)) ? f_other_a(d, j) : f_other_b(d, j);
        hi  = (f_other_a(d, j) < f_other_b(d, j)) ? f_other_b(d, j) : f_other_a(d, j);
        idx = 0;
        for (int p = 0; p < NUM_PAIR; p++) begin
            if (PAIR_P[p] == lo && PAIR_Q[p] == hi) begin
                idx = p;
            end
        end
        return idx;
    endfunction

    // cofactor sign, flipped again when the minor columns come reversed
    function automatic logic f_term_neg(input int d, input int j);
        logic base;
        logic rev;
        base = (j == 1);
        rev  = (f_other_a(d, j) > f_other_b(d, j));
        return base ^ rev;
    endfunction

endpackage

FILE: sv/cramer_3x3_solver.sv
// top level of the cramer 3x3 solver: front, item queue, back, result queue
// depends on csol_pkg, csol_front, csol_fifo, csol_back and the defines header
//
// Takes one 3x3 system per clock unless o_full is set and returns x1..x3 in
// signed fixed point with FRAC_BITS fractional bits, truncated toward zero and
// saturated to 48 bits, or zeros with o_singular set when the main determinant
// is zero. Throughput is one item per cycle when neither side stalls. The
// accepting edge loads the first of four determinant stages, the front's result
// is written into the four-entry queue between front and back, 51 divider
// stages follow (one quotient bit per stage over 48 bits plus magnitude, setup
// and clamp) and the result is written into the two-entry result queue. The
// divider pipeline length sets the latency. Each side stalls on its own: the
// front holds only when the middle queue fills, the back only when the result queue is full.
`include "cramer_3x3_solver_defines.svh"

module cramer_3x3_solver
    import csol_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [COEF_WIDTH-1:0] i_a11,
    input  logic signed [COEF_WIDTH-1:0] i_a12,
    input  logic signed [COEF_WIDTH-1:0] i_a13,
    input  logic signed [COEF_WIDTH-1:0] i_a21,
    input  logic signed [COEF_WIDTH-1:0] i_a22,
    input  logic signed [COEF_WIDTH-1:0] i_a23,
    input  logic signed [COEF_WIDTH-1:0] i_a31,
    input  logic signed [COEF_WIDTH-1:0] i_a32,
    input  logic signed [COEF_WIDTH-1:0] i_a33,
    input  logic signed [COEF_WIDTH-1:0] i_k1,
    input  logic signed [COEF_WIDTH-1:0] i_k2,
    input  logic signed [COEF_WIDTH-1:0] i_k3,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic signed [OUT_W-1:0]      o_x1,
    output logic signed [OUT_W-1:0]      o_x2,
    output logic signed [OUT_W-1:0]      o_x3,
    output logic                         o_singular
);

    localparam int DW = 3 * COEF_WIDTH + 3;
    localparam int MQ = NUM_DET * DW;
    localparam int RQ = 3 * OUT_W + 1;

    logic signed [COEF_WIDTH-1:0] w_top [NUM_COL];
    logic signed [COEF_WIDTH-1:0] w_r2  [NUM_COL];
    logic signed [COEF_WIDTH-1:0] w_r3  [NUM_COL];

    logic                 w_f_en;
    logic                 w_f_valid;
    logic signed [DW-1:0] w_f_det [NUM_DET];

    logic          w_mid_push;
    logic          w_mid_full;
    logic          w_mid_pop;
    logic          w_mid_empty;
    logic [MQ-1:0] w_mid_in;
    logic [MQ-1:0] w_mid_out;

    logic                    w_b_en;
    logic                    w_b_valid;
    logic signed [DW-1:0]    w_b_dm;
    logic signed [DW-1:0]    w_b_dn [3];
    logic signed [OUT_W-1:0] w_b_x  [3];
    logic                    w_b_sing;

    logic          w_out_push;
    logic          w_out_full;
    logic [RQ-1:0] w_out_in;
    logic [RQ-1:0] w_out_out;

    // rows of the system, constants as the fourth column
    assign w_top = '{i_a11, i_a12, i_a13, i_k1};
    assign w_r2  = '{i_a21, i_a22, i_a23, i_k2};
    assign w_r3  = '{i_a31, i_a32, i_a33, i_k3};

    // front stalls only when its last item cannot enter the queue
    assign w_f_en     = !(w_f_valid && w_mid_full);
    assign o_full     = !w_f_en;
    assign w_mid_push = w_f_valid && !w_mid_full;
    assign w_mid_in   = {w_f_det[0], w_f_det[1], w_f_det[2], w_f_det[3]};

    csol_front #(
        .CW (COEF_WIDTH),
        .DW (DW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_f_en),
        .i_valid (i_push),
        .i_top   (w_top),
        .i_r2    (w_r2),
        .i_r3    (w_r3),
        .o_valid (w_f_valid),
        .o_det   (w_f_det)
    );

    csol_fifo #(
        .W     (MQ),
        .DEPTH (4)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    // back stalls only when its result cannot enter the result queue
    assign w_b_en     = !(w_b_valid && w_out_full);
    assign w_mid_pop  = w_b_en && !w_mid_empty;
    assign w_b_dm     = signed'(w_mid_out[4*DW-1:3*DW]);
    assign w_b_dn[0]  = signed'(w_mid_out[3*DW-1:2*DW]);
    assign w_b_dn[1]  = signed'(w_mid_out[2*DW-1:DW]);
    assign w_b_dn[2]  = signed'(w_mid_out[DW-1:0]);

    csol_back #(
        .CW (COEF_WIDTH),
        .FB (FRAC_BITS),
        .DW (DW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_b_en),
        .i_valid    (!w_mid_empty),
        .i_dm       (w_b_dm),
        .i_dn       (w_b_dn),
        .o_valid    (w_b_valid),
        .o_x        (w_b_x),
        .o_singular (w_b_sing)
    );

    assign w_out_push = w_b_valid && !w_out_full;
    assign w_out_in   = {w_b_x[0], w_b_x[1], w_b_x[2], w_b_sing};

    csol_fifo #(
        .W     (RQ),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_in),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_out),
        .o_empty (o_empty)
    );

    // result item fields
    assign o_x1       = signed'(w_out_out[RQ-1:2*OUT_W+1]);
    assign o_x2       = signed'(w_out_out[2*OUT_W:OUT_W+1]);
    assign o_x3       = signed'(w_out_out[OUT_W:1]);
    assign o_singular = w_out_out[0];

    `CSOL_ASSERT_IMPL(a_full_from_mid, o_full, w_mid_full)
    `CSOL_ASSERT_IMPL(a_singular_zero, !o_empty && o_singular,
        o_x1 == '0 && o_x2 == '0 && o_x3 == '0)
    `CSOL_ASSERT_IMPL(a_back_stall_holds, w_b_valid && w_out_full, !w_mid_pop)

endmodule

FILE: sv/csol_fifo.sv
// small first-in first-out queue with a combinational read port
// depends on csol_pkg and cramer_3x3_solver_defines.svh
`include "cramer_3x3_solver_defines.svh"

module csol_fifo
    import csol_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `CSOL_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= (AW + 1)'(DEPTH))
    `CSOL_ASSERT_NEXT(a_push_fills, w_wr && !w_rd, !o_empty)
    `CSOL_ASSERT_NEXT(a_last_drains, w_rd && !w_wr && r_cnt == (AW + 1)'(1), o_empty)

endmodule

FILE: sv/csol_front.sv
// front end: four determinants by cofactor expansion, four pipeline stages
// depends on csol_pkg
module csol_front
    import csol_pkg::*;
#(
    parameter int CW = 16,
    parameter int DW = 3 * CW + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_top [NUM_COL],
    input  logic signed [CW-1:0] i_r2  [NUM_COL],
    input  logic signed [CW-1:0] i_r3  [NUM_COL],
    output logic                 o_valid,
    output logic signed [DW-1:0] o_det [NUM_DET]
);

    localparam int PW = 2 * CW;
    localparam int MW = 2 * CW + 1;
    localparam int TW = 3 * CW + 1;

    logic [3:0]          r_v;
    logic signed [CW-1:0] r1_top [NUM_COL];
    logic signed [PW-1:0] r1_pa  [NUM_PAIR];
    logic signed [PW-1:0] r1_pb  [NUM_PAIR];
    logic signed [CW-1:0] r2_top [NUM_COL];
    logic signed [MW-1:0] r2_mn  [NUM_PAIR];
    logic signed [TW-1:0] r3_tm  [NUM_DET][3];
    logic signed [DW-1:0] r4_det [NUM_DET];
    logic signed [DW-1:0] w_sum  [NUM_DET];

    // stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // stage 1: cross products of rows two and three
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_top <= i_top;
            for (int p = 0; p < NUM_PAIR; p++) begin
                r1_pa[p] <= i_r2[PAIR_P[p]] * i_r3[PAIR_Q[p]];
                r1_pb[p] <= i_r2[PAIR_Q[p]] * i_r3[PAIR_P[p]];
            end
        end
    end

    // stage 2: 2x2 minors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_top <= r1_top;
            for (int p = 0; p < NUM_PAIR; p++) begin
                r2_mn[p] <= MW'(r1_pa[p]) - MW'(r1_pb[p]);
            end
        end
    end

    // stage 3: first-row entry times minor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int d = 0; d < NUM_DET; d++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_tm[d][j] <= r2_top[f_term_col(d, j)] * r2_mn[f_term_pair(d, j)];
                end
            end
        end
    end

    // stage 4: signed sum of the three terms
    always_comb begin
        for (int d = 0; d < NUM_DET; d++) begin
            w_sum[d] = '0;
            for (int j = 0; j < 3; j++) begin
                if (f_term_neg(d, j)) begin
                    w_sum[d] = w_sum[d] - DW'(r3_tm[d][j]);
                end else begin
                    w_sum[d] = w_sum[d] + DW'(r3_tm[d][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_det <= w_sum;
        end
    end

    assign o_valid = r_v[3];
    assign o_det   = r4_det;

endmodule

FILE: sv/csol_back.sv
// back end: three pipelined restoring dividers, one quotient bit per stage
// depends on csol_pkg
module csol_back
    import csol_pkg::*;
#(
    parameter int CW = 16,
    parameter int FB = 16,
    parameter int DW = 3 * CW + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [DW-1:0]    i_dm,
    input  logic signed [DW-1:0]    i_dn [3],
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_x  [3],
    output logic                    o_singular
);

    localparam int QW = OUT_W;
    localparam int SH = OUT_W - FB;
    localparam int NS = OUT_W;
    localparam logic [QW:0] CAP     = (QW + 1)'(1) << QW;
    localparam logic [QW:0] NEG_MAX = (QW + 1)'(1) << (QW - 1);
    localparam logic [QW:0] POS_MAX = NEG_MAX - 1'b1;

    // stage 0: magnitudes and signs
    logic          r0_v;
    logic          r0_sing;
    logic [DW-1:0] r0_d;
    logic [DW-1:0] r0_a   [3];
    logic          r0_neg [3];

    // divide stages, index 0 holds the starting remainder
    logic          rd_v    [0:NS];
    logic          rd_sing [0:NS];
    logic [DW-1:0] rd_d    [0:NS];
    logic [DW-1:0] rd_a    [0:NS][3];
    logic [DW-1:0] rd_r    [0:NS][3];
    logic [QW-1:0] rd_q    [0:NS][3];
    logic          rd_neg  [0:NS][3];
    logic          rd_sat  [0:NS][3];

    // output stage
    logic          ro_v;
    logic          ro_sing;
    logic [QW-1:0] ro_x [3];
    logic [QW:0]   w_qm  [3];
    logic [QW:0]   w_mag [3];
    logic [QW-1:0] w_x   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_sing <= (i_dm == '0);
            r0_d    <= i_dm[DW-1] ? DW'(-i_dm) : DW'(i_dm);
            for (int l = 0; l < 3; l++) begin
                r0_a[l]   <= i_dn[l][DW-1] ? DW'(-i_dn[l]) : DW'(i_dn[l]);
                r0_neg[l] <= i_dn[l][DW-1] ^ i_dm[DW-1];
            end
        end
    end

    // saturation check and starting remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v[0] <= 1'b0;
        end else if (i_en) begin
            rd_v[0] <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rd_sing[0] <= r0_sing;
            rd_d[0]    <= r0_d;
            for (int l = 0; l < 3; l++) begin
                rd_a[0][l]   <= r0_a[l];
                rd_r[0][l]   <= r0_a[l] >> SH;
                rd_q[0][l]   <= '0;
                rd_neg[0][l] <= r0_neg[l];
                rd_sat[0][l] <= (DW + SH)'(r0_a[l]) >= ((DW + SH)'(r0_d) << SH);
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= NS; k++) begin : g_step
        localparam int BI = OUT_W - k;

        logic          w_nb [3];
        logic [DW:0]   w_t  [3];
        logic          w_ge [3];

        for (genvar l = 0; l < 3; l++) begin : g_lane
            if (BI >= FB && BI - FB < DW) begin : g_bit
                assign w_nb[l] = rd_a[k-1][l][BI-FB];
            end else begin : g_zero
                assign w_nb[l] = 1'b0;
            end
            assign w_t[l]  = {rd_r[k-1][l], w_nb[l]};
            assign w_ge[l] = (w_t[l] >= {1'b0, rd_d[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_v[k] <= 1'b0;
            end else if (i_en) begin
                rd_v[k] <= rd_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                rd_sing[k] <= rd_sing[k-1];
                rd_d[k]    <= rd_d[k-1];
                for (int l = 0; l < 3; l++) begin
                    rd_a[k][l]   <= rd_a[k-1][l];
                    rd_r[k][l]   <= w_ge[l] ? DW'(w_t[l] - {1'b0, rd_d[k-1]}) : DW'(w_t[l]);
                    rd_q[k][l]   <= {rd_q[k-1][l][QW-2:0], w_ge[l]};
                    rd_neg[k][l] <= rd_neg[k-1][l];
                    rd_sat[k][l] <= rd_sat[k-1][l];
                end
            end
        end
    end

    // clamp, apply sign, zero when singular
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_qm[l] = rd_sat[NS][l] ? CAP : {1'b0, rd_q[NS][l]};
            if (rd_neg[NS][l]) begin
                w_mag[l] = (w_qm[l] > NEG_MAX) ? NEG_MAX : w_qm[l];
                w_x[l]   = QW'(-w_mag[l]);
            end else begin
                w_mag[l] = (w_qm[l] > POS_MAX) ? POS_MAX : w_qm[l];
                w_x[l]   = QW'(w_mag[l]);
            end
            if (rd_sing[NS]) begin
                w_x[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ro_v <= 1'b0;
        end else if (i_en) begin
            ro_v <= rd_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ro_sing <= rd_sing[NS];
            ro_x    <= w_x;
        end
    end

    assign o_valid    = ro_v;
    assign o_singular = ro_sing;
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_x[l] = signed'(ro_x[l]);
    end

endmodule
